/* rtl/pdsc_pkg.sv */
`timescale 1ns / 1ps

package pdsc_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned DistW  = 12;
    localparam int unsigned AngleW = 8;
    localparam int unsigned IntvW  = 16;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 32;

    typedef enum logic [1:0] {
        MODE_CLOSED  = 2'd0,
        MODE_OPENING = 2'd1,
        MODE_OPEN    = 2'd2,
        MODE_CLOSING = 2'd3
    } t_door_mode;

    typedef enum logic [CfgIdxW-1:0] {
        REG_NEAR_LIMIT    = 3'd0,
        REG_OPEN_ANGLE    = 3'd1,
        REG_CLOSED_ANGLE  = 3'd2,
        REG_RAMP_STEP     = 3'd3,
        REG_STEP_INTERVAL = 3'd4,
        REG_HOLD_TIME     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [DistW-1:0]  near_limit;
        logic [AngleW-1:0] open_angle;
        logic [AngleW-1:0] closed_angle;
        logic [AngleW-1:0] ramp_step;
        logic [IntvW-1:0]  step_interval;
        logic [TimeW-1:0]  hold_time;
    } t_cfg;

    typedef struct packed {
        t_door_mode        door_mode;
        logic [AngleW-1:0] servo_angle;
        logic              servo_write;
    } t_result;

endpackage

/* rtl/pdsc_if.sv */
`timescale 1ns / 1ps

interface pdsc_in_if;
    import pdsc_pkg::*;
    logic             valid;
    logic             ready;
    logic [TimeW-1:0] now_ms;
    logic [DistW-1:0] distance;
    modport source (output valid, output now_ms, output distance, input ready);
    modport sink   (input valid, input now_ms, input distance, output ready);
endinterface

interface pdsc_out_if;
    import pdsc_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        door_mode;
    logic [AngleW-1:0] servo_angle;
    logic              servo_write;
    modport source (output valid, output door_mode, output servo_angle,
                    output servo_write, input ready);
    modport sink   (input valid, input door_mode, input servo_angle,
                    input servo_write, output ready);
endinterface

interface pdsc_cfg_if;
    import pdsc_pkg::*;
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/pdsc_cfg.sv */
`timescale 1ns / 1ps

module pdsc_cfg
    import pdsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pdsc_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_limit    <= DistW'(20);
            r_cfg.open_angle    <= AngleW'(90);
            r_cfg.closed_angle  <= AngleW'(0);
            r_cfg.ramp_step     <= AngleW'(5);
            r_cfg.step_interval <= IntvW'(20);
            r_cfg.hold_time     <= TimeW'(3000);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_NEAR_LIMIT:    r_cfg.near_limit    <= i_cfg.data[DistW-1:0];
                REG_OPEN_ANGLE:    r_cfg.open_angle    <= i_cfg.data[AngleW-1:0];
                REG_CLOSED_ANGLE:  r_cfg.closed_angle  <= i_cfg.data[AngleW-1:0];
                REG_RAMP_STEP:     r_cfg.ramp_step     <= i_cfg.data[AngleW-1:0];
                REG_STEP_INTERVAL: r_cfg.step_interval <= i_cfg.data[IntvW-1:0];
                REG_HOLD_TIME:     r_cfg.hold_time     <= i_cfg.data[TimeW-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* rtl/pdsc_ramp.sv */
`timescale 1ns / 1ps

module pdsc_ramp
    import pdsc_pkg::*;
(
    input  logic [AngleW-1:0] i_angle,
    input  logic [AngleW-1:0] i_target,
    input  logic [AngleW-1:0] i_step,
    input  logic [TimeW-1:0]  i_now_ms,
    input  logic [TimeW-1:0]  i_last_step_ms,
    input  logic [IntvW-1:0]  i_interval,
    output logic              o_due,
    output logic [AngleW-1:0] o_angle
);

    logic [TimeW-1:0]  elapsed;
    logic [AngleW:0]   sum;
    logic [AngleW-1:0] gap;

    always_comb begin
        elapsed = i_now_ms - i_last_step_ms;
        o_due   = (elapsed >= TimeW'(i_interval));
        sum     = {1'b0, i_angle} + {1'b0, i_step};
        gap     = i_angle - i_target;
        if (i_angle < i_target) begin
            o_angle = (sum >= {1'b0, i_target}) ? i_target : sum[AngleW-1:0];
        end else begin
            // falling: clamp when the step would reach or pass the target
            o_angle = (i_step >= gap) ? i_target : (i_angle - i_step);
        end
    end

endmodule

/* rtl/pdsc_fsm.sv */
`timescale 1ns / 1ps

module pdsc_fsm
    import pdsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  t_cfg             i_cfg,
    input  logic [TimeW-1:0] i_now_ms,
    input  logic [DistW-1:0] i_distance,
    output t_result          o_result
);

    t_door_mode        r_state,   n_state;
    logic [AngleW-1:0] r_angle,   n_angle;
    logic [TimeW-1:0]  r_last_step_ms,     n_last_step_ms;
    logic [TimeW-1:0]  r_last_presence_ms, n_last_presence_ms;

    logic              near;
    logic              wrote;
    logic              step_due;
    logic [AngleW-1:0] ramp_angle;
    logic [AngleW-1:0] target;
    logic [TimeW-1:0]  idle_ms;

    assign target = (r_state == MODE_OPENING) ? i_cfg.open_angle : i_cfg.closed_angle;

    pdsc_ramp u_ramp (
        .i_angle        (r_angle),
        .i_target       (target),
        .i_step         (i_cfg.ramp_step),
        .i_now_ms       (i_now_ms),
        .i_last_step_ms (r_last_step_ms),
        .i_interval     (i_cfg.step_interval),
        .o_due          (step_due),
        .o_angle        (ramp_angle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= MODE_CLOSED;
            r_angle            <= '0;
            r_last_step_ms     <= '0;
            r_last_presence_ms <= '0;
        end else if (i_advance) begin
            r_state            <= n_state;
            r_angle            <= n_angle;
            r_last_step_ms     <= n_last_step_ms;
            r_last_presence_ms <= n_last_presence_ms;
        end
    end

    always_comb begin
        near               = (i_distance != '0) && (i_distance <= i_cfg.near_limit);
        idle_ms            = i_now_ms - r_last_presence_ms;
        n_state            = r_state;
        n_angle            = r_angle;
        n_last_step_ms     = r_last_step_ms;
        n_last_presence_ms = r_last_presence_ms;
        wrote              = 1'b0;
        unique case (r_state)
            MODE_CLOSED: begin
                if (near) n_state = MODE_OPENING;
            end
            MODE_OPENING: begin
                if (step_due) begin
                    n_angle        = ramp_angle;
                    n_last_step_ms = i_now_ms;
                    wrote          = 1'b1;
                end
                if (n_angle == i_cfg.open_angle) begin
                    n_last_presence_ms = i_now_ms;
                    n_state            = MODE_OPEN;
                end
            end
            MODE_OPEN: begin
                if (near) begin
                    n_last_presence_ms = i_now_ms;
                end else if (idle_ms > i_cfg.hold_time) begin
                    n_state = MODE_CLOSING;
                end
            end
            MODE_CLOSING: begin
                if (near) begin
                    n_state = MODE_OPENING;
                end else begin
                    if (step_due) begin
                        n_angle        = ramp_angle;
                        n_last_step_ms = i_now_ms;
                        wrote          = 1'b1;
                    end
                    if (n_angle == i_cfg.closed_angle) n_state = MODE_CLOSED;
                end
            end
            default: n_state = MODE_CLOSED;
        endcase
        o_result.door_mode   = n_state;
        o_result.servo_angle = n_angle;
        o_result.servo_write = wrote;
    end

endmodule

/* rtl/proximity_door_servo_controller.sv */
`timescale 1ns / 1ps
// Path: an accepted input is held in the input register, and its result is then
// registered in the result register, from which o_out presents it.
// Throughput: one item per cycle unless o_out.ready stalls the output; the door state
// update is one pass of compares, an add and 32/8-bit subtracts between both registers.
// Reset (i_rst_n low, synchronous): door closed, angle 0, timestamps 0,
// configuration registers back to their defaults, both pipeline registers empty.

module proximity_door_servo_controller
    import pdsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdsc_in_if.sink     i_in,
    pdsc_out_if.source  o_out,
    pdsc_cfg_if.sink    i_cfg
);

    t_cfg             cfg;
    t_result          result;
    logic             advance;
    logic             out_free;

    logic             r_in_valid;
    logic [TimeW-1:0] r_now_ms;
    logic [DistW-1:0] r_distance;
    logic             r_out_valid;
    t_result          r_result;

    pdsc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    pdsc_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_cfg      (cfg),
        .i_now_ms   (r_now_ms),
        .i_distance (r_distance),
        .o_result   (result)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (out_free)   r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_now_ms   <= i_in.now_ms;
            r_distance <= i_in.distance;
        end
        if (advance) r_result <= result;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.door_mode   = r_result.door_mode;
    assign o_out.servo_angle = r_result.servo_angle;
    assign o_out.servo_write = r_result.servo_write;

endmodule
